FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the oscillator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SSO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SSO_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SSO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sso_pkg.sv
// Shared types, constants and the sine table of the servo oscillator.
package sso_pkg;

    localparam int PHASE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int TIME_BITS        = 32;

    localparam int FRAC_W = PHASE_BITS - 2;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDXP_W = FRAC_W + IDX_W;

    localparam logic [6:0]  AMP_MAX     = 7'd90;
    localparam logic [18:0] DEG2RAD_Q24 = 19'd292818;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SAMPLE_PERIOD = 3'd0,
        CFG_PHASE_STEP    = 3'd1,
        CFG_AMPLITUDE     = 3'd2,
        CFG_PHASE_OFFSET  = 3'd3,
        CFG_STOP_OUTPUT   = 3'd4,
        CFG_REVERSE       = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] sample_period_ms;
        logic [15:0] phase_step;
        logic [6:0]  amplitude_deg;
        logic [15:0] phase_offset;
        logic        stop_output;
        logic        reverse;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Quarter-wave sine in Q1.15, Taylor series in Q30 rounded to Q15
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            if (sum < 0)
            begin
                sum = 64'sd0;
            end
            r = (64'(sum) + 64'd16384) >> 15;
            if (r > 64'd32768)
            begin
                r = 64'd32768;
            end
            rom[i] = r[15:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/sine_servo_oscillator.sv
// An accepted time request passes the queue, table and product registers, then the output register.
// One request per cycle is accepted while the two-entry queue has room; in_stall holds it when full.
// Requests that fall inside the sample period or arrive with output stopped give no result.
// Reset (rst_n low, asynchronous) clears phase and last sample time and loads the default
// configuration: period 30 ms, step 993, amplitude 45 deg, offset 0, running, not reversed.
module sine_servo_oscillator
    import sso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [7:0]  position_deg,
    output logic signed [14:0] position_rad
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    fifo_stat_t fifo_stat;
    logic       push;
    phase_t     push_phase;
    logic       pop;
    phase_t     head_phase;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_SAMPLE_PERIOD: cfg_next.sample_period_ms = cfg_wdata;
                CFG_PHASE_STEP:    cfg_next.phase_step       = cfg_wdata;
                CFG_AMPLITUDE:     cfg_next.amplitude_deg    = cfg_wdata[6:0];
                CFG_PHASE_OFFSET:  cfg_next.phase_offset     = cfg_wdata;
                CFG_STOP_OUTPUT:   cfg_next.stop_output      = cfg_wdata[0];
                CFG_REVERSE:       cfg_next.reverse          = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period_ms <= 16'd30;
            cfg_reg.phase_step       <= 16'd993;
            cfg_reg.amplitude_deg    <= 7'd45;
            cfg_reg.phase_offset     <= 16'd0;
            cfg_reg.stop_output      <= 1'b0;
            cfg_reg.reverse          <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sso_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_phase (push_phase)
    );

    sso_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_phase (push_phase),
        .pop        (pop),
        .head_phase (head_phase),
        .stat       (fifo_stat)
    );

    sso_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_stat    (fifo_stat),
        .head_phase   (head_phase),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position_deg (position_deg),
        .position_rad (position_rad)
    );

endmodule

FILE: rtl/sso_front.sv
// Front end: accepts time requests, gates on the sample period, advances phase.
module sso_front
    import sso_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           now_ms,
    input  fifo_stat_t            fifo_stat,
    output logic                  push,
    output phase_t                push_phase
);

    time_t  last_sample_reg;
    time_t  last_sample_next;
    phase_t phase_reg;
    phase_t phase_next;
    time_t  now_t;
    time_t  diff;
    logic   accept;
    logic   hit;

    // Hold off requests while the queue has no room
    assign in_stall = fifo_stat.full;
    assign accept   = in_valid && !in_stall;

    // Compare wrapped elapsed time against the period
    assign now_t = TIME_BITS'(now_ms);
    assign diff  = now_t - last_sample_reg;
    assign hit   = diff > TIME_BITS'(cfg.sample_period_ms);

    // Queue the sampled phase unless output is stopped
    assign push       = accept && hit && !cfg.stop_output;
    assign push_phase = phase_reg + PHASE_BITS'(cfg.phase_offset);

    // Advance time stamp and phase on each sample
    always_comb
    begin
        last_sample_next = last_sample_reg;
        phase_next       = phase_reg;
        if (accept && hit)
        begin
            last_sample_next = now_t;
            phase_next       = phase_reg + PHASE_BITS'(cfg.phase_step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            last_sample_reg <= last_sample_next;
            phase_reg       <= phase_next;
        end
    end

endmodule

FILE: rtl/sso_fifo.sv
// Two-entry queue of sample phases between front and back ends.
module sso_fifo
    import sso_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  phase_t     push_phase,
    input  logic       pop,
    output phase_t     head_phase,
    output fifo_stat_t stat
);

    phase_t     mem [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign stat.full   = (count_reg == 2'd2);
    assign stat.empty  = (count_reg == 2'd0);
    assign do_push     = push && !stat.full;
    assign do_pop      = pop && !stat.empty;
    assign head_phase  = mem[rd_ptr_reg];

    // Update pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming phase
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_phase;
        end
    end

endmodule

FILE: rtl/sso_back.sv
// Back end: sine lookup, amplitude scaling and degree-to-radian conversion.
module sso_back
    import sso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  fifo_stat_t         fifo_stat,
    input  phase_t             head_phase,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [7:0]  position_deg,
    output logic signed [14:0] position_rad
);

    logic              advance;
    logic [1:0]        quad;
    logic [FRAC_W-1:0] frac;
    logic [IDXP_W-1:0] idx_wide;
    logic [IDX_W-1:0]  idx_raw;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  rom_addr;
    logic [6:0]        amp_sat;
    logic [23:0]       dmag_sum;
    logic [6:0]        dmag;
    logic [25:0]       rmag_prod;
    logic [13:0]       rmag;

    logic              v1_reg;
    logic              v1_next;
    logic              v2_reg;
    logic              v2_next;
    logic              v3_reg;
    logic              v3_next;
    logic [15:0]       smag1_reg;
    logic              neg1_reg;
    logic [22:0]       prod2_reg;
    logic              neg2_reg;
    logic signed [7:0] deg_reg;
    logic [14:0]       rad_reg;

    // Move the whole pipeline only when the output register frees up
    assign advance = !v3_reg || !out_stall;
    assign pop     = advance && !fifo_stat.empty;

    // Map phase to a quarter-wave table address
    assign quad     = head_phase[PHASE_BITS-1 -: 2];
    assign frac     = head_phase[FRAC_W-1:0];
    assign idx_wide = IDXP_W'(frac) * IDXP_W'(SINE_TABLE_DEPTH)
                    + IDXP_W'(1 << (FRAC_W - 1));
    assign idx_raw  = IDX_W'(idx_wide >> FRAC_W);
    assign idx      = (idx_raw > IDX_W'(SINE_TABLE_DEPTH)) ?
                      IDX_W'(SINE_TABLE_DEPTH) : idx_raw;
    assign rom_addr = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;

    // Clamp amplitude to the mechanical range
    assign amp_sat = (cfg.amplitude_deg > AMP_MAX) ? AMP_MAX : cfg.amplitude_deg;

    // Round degrees, then scale to radians
    assign dmag_sum  = 24'(prod2_reg) + 24'd16384;
    assign dmag      = 7'(dmag_sum >> 15);
    assign rmag_prod = 26'(dmag) * 26'(DEG2RAD_Q24) + 26'd1024;
    assign rmag      = 14'(rmag_prod >> 11);

    // Stage valid bits
    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (advance)
        begin
            v1_next = pop;
            v2_next = v1_reg;
            v3_next = v2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage data: table read, amplitude product, signed result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            smag1_reg <= SINE_ROM[rom_addr];
            neg1_reg  <= quad[1] ^ cfg.reverse;
            prod2_reg <= 23'(amp_sat) * 23'(smag1_reg);
            neg2_reg  <= neg1_reg;
            deg_reg   <= neg2_reg ? (8'sd0 - $signed(8'(dmag))) : $signed(8'(dmag));
            rad_reg   <= neg2_reg ? (15'd0 - 15'(rmag)) : 15'(rmag);
        end
    end

    assign out_valid    = v3_reg;
    assign position_deg = deg_reg;
    assign position_rad = $signed(rad_reg);

endmodule

FILE: rtl/sso_checker.sv
// Port-level checker for the servo oscillator, bound to the top level.
`include "assert_macros.svh"

module sso_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [7:0]  position_deg,
    input logic signed [14:0] position_rad
);

    // Hold a stalled result
    `SSO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(position_deg) && $stable(position_rad), "stalled result changed")

    // Keep the angle within the mechanical range
    `SSO_ASSERT_IMPLY(a_deg_range, clk, rst_n, out_valid, (position_deg <= 8'sd90) && (position_deg >= -8'sd90), "degree angle out of range")

    // Zero degrees and zero radians go together
    `SSO_ASSERT_IMPLY(a_zero_match, clk, rst_n, out_valid, (position_deg == 8'sd0) == (position_rad == 15'sd0), "degree and radian zero mismatch")

    // Both angle forms carry the same sign
    `SSO_ASSERT_IMPLY(a_sign_match, clk, rst_n, out_valid && (position_deg != 8'sd0), position_deg[7] == position_rad[14], "degree and radian sign mismatch")

endmodule

bind sine_servo_oscillator sso_checker u_sso_checker (.*);

FILE: bench/sine_servo_oscillator_test.sv
// Self-checking testbench for the sine servo oscillator: directed table, then random sampling.
`timescale 1ns / 100ps

module sine_servo_oscillator_test;
    import sso_pkg::*;

    localparam int QUARTER     = 256;
    localparam int DRAIN       = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 60;

    typedef struct {
        logic signed [7:0]  deg;
        logic signed [14:0] rad;
    } angle_t;

    typedef enum {ROW_WRITE, ROW_TIME} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        cfg_index_t reg_idx;
        logic [31:0] value;
        bit         typed;
        bit         gives;
        int         deg;
        int         rad;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [7:0]  position_deg;
    logic signed [14:0] position_rad;

    // Shadow configuration and oscillator state
    logic [15:0] period_ms;
    logic [15:0] step;
    logic [6:0]  amp;
    logic [15:0] offset;
    logic        stop;
    logic        rev;
    logic [31:0] last_ms;
    logic [15:0] phase_acc;

    int unsigned quarter_sine [0:QUARTER];
    angle_t      expected_angles [$];
    row_t        plan [$];

    // Pinned expectation of the request now on the input
    bit  pin_on;
    bit  pin_gives;
    int  pin_deg;
    int  pin_rad;

    int  errors;
    int  samples_taken;
    int  quiet_cycles;
    int  stall_left;
    bit  steady;

    sine_servo_oscillator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position_deg (position_deg),
        .position_rad (position_rad)
    );

    always #4 clk = ~clk;

    // Sine of a quarter-table point: Taylor series in Q30, rounded to Q15
    function automatic int unsigned taylor_q15(input int i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        x    = (64'd1686629713 * longint'(i)) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (longint'(acc) + 64'd16384) >> 15;
        if (r > 64'd32768)
        begin
            r = 64'd32768;
        end
        return int'(r);
    endfunction

    // Signed Q15 sine of a 16-bit phase via the quarter-wave table
    function automatic int sine_q15(input logic [15:0] p);
        logic [1:0]  quad;
        int unsigned idx;
        int          v;
        quad = p[15:14];
        idx  = (int'(p[13:0]) * QUARTER + 8192) >> 14;
        if (idx > QUARTER)
        begin
            idx = QUARTER;
        end
        v = quad[0] ? int'(quarter_sine[QUARTER - idx]) : int'(quarter_sine[idx]);
        return quad[1] ? -v : v;
    endfunction

    // Take a sample if the period has elapsed; returns 1 when state moved
    function automatic bit take_sample(input logic [31:0] t, output bit gives,
                                       output angle_t a);
        logic [31:0] diff;
        int          s;
        int unsigned mag;
        int unsigned lim;
        int unsigned dmag;
        int unsigned rmag;
        bit          neg;
        gives = 1'b0;
        a.deg = '0;
        a.rad = '0;
        diff  = t - last_ms;
        if (diff <= {16'd0, period_ms})
        begin
            return 1'b0;
        end
        last_ms = t;
        if (!stop)
        begin
            s     = sine_q15(phase_acc + offset);
            mag   = (s < 0) ? -s : s;
            lim   = (amp > 7'd90) ? 90 : amp;
            dmag  = (lim * mag + 16384) >> 15;
            neg   = (s < 0) ^ rev;
            rmag  = (dmag * 292818 + 1024) >> 11;
            a.deg = 8'(neg ? -int'(dmag) : int'(dmag));
            a.rad = 15'(neg ? -int'(rmag) : int'(rmag));
            gives = 1'b1;
        end
        phase_acc = phase_acc + step;
        return 1'b1;
    endfunction

    // Mostly short spans, a few long ones
    function automatic int span_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic row_t w(input cfg_index_t idx, input logic [15:0] val);
        return '{ROW_WRITE, idx, {16'd0, val}, 1'b0, 1'b0, 0, 0};
    endfunction

    function automatic row_t tm(input logic [31:0] t);
        return '{ROW_TIME, CFG_SAMPLE_PERIOD, t, 1'b0, 1'b0, 0, 0};
    endfunction

    function automatic row_t tp(input logic [31:0] t, input bit gives,
                                input int deg, input int rad);
        return '{ROW_TIME, CFG_SAMPLE_PERIOD, t, 1'b1, gives, deg, rad};
    endfunction

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        unique case (idx)
            CFG_SAMPLE_PERIOD: period_ms = val;
            CFG_PHASE_STEP:    step      = val;
            CFG_AMPLITUDE:     amp       = val[6:0];
            CFG_PHASE_OFFSET:  offset    = val;
            CFG_STOP_OUTPUT:   stop      = val[0];
            CFG_REVERSE:       rev       = val[0];
            default:           ;
        endcase
        @(negedge clk);
    endtask

    task automatic write_all(input logic [15:0] per, input logic [15:0] stp,
                             input logic [6:0] am, input logic [15:0] off,
                             input logic st, input logic rv);
        write_reg(CFG_SAMPLE_PERIOD, per);
        write_reg(CFG_PHASE_STEP, stp);
        write_reg(CFG_AMPLITUDE, {9'd0, am});
        write_reg(CFG_PHASE_OFFSET, off);
        write_reg(CFG_STOP_OUTPUT, {15'd0, st});
        write_reg(CFG_REVERSE, {15'd0, rv});
    endtask

    // Drop the request and wait until every expected angle is out
    task automatic wait_empty();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (expected_angles.size() != 0);
    endtask

    // Idle the block fully before touching configuration
    task automatic settle();
        wait_empty();
        repeat (DRAIN) @(negedge clk);
    endtask

    // Present one time request and hold it until accepted
    task automatic send_time(input logic [31:0] t, input bit typed, input bit gives,
                             input int deg, input int rad);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : span_len();
        cfg_wr_en <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_on    = typed;
        pin_gives = gives;
        pin_deg   = deg;
        pin_rad   = rad;
        now_ms   <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Receiver stalls in random spans
    always @(negedge clk)
    begin
        if (!rst_n || steady)
        begin
            out_stall  <= 1'b0;
            stall_left  = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        else if (!out_stall && $urandom_range(0, 99) < 40)
        begin
            out_stall  <= 1'b1;
            stall_left  = span_len();
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left  = $urandom_range(0, 30);
        end
    end

    // Check angles, predict on each accepted request, watch for a hang
    always @(posedge clk)
    begin
        angle_t got;
        angle_t want;
        bit     gives;
        if (rst_n)
        begin
            quiet_cycles++;
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                got.deg = position_deg;
                got.rad = position_rad;
                if (expected_angles.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected angle, expected none, got deg %0d rad %0d",
                             $time, got.deg, got.rad);
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (got.deg !== want.deg)
                    begin
                        errors++;
                        $display("%0t: position_deg expected %0d got %0d",
                                 $time, want.deg, got.deg);
                    end
                    if (got.rad !== want.rad)
                    begin
                        errors++;
                        $display("%0t: position_rad expected %0d got %0d",
                                 $time, want.rad, got.rad);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                if (take_sample(now_ms, gives, want))
                begin
                    samples_taken++;
                end
                if (pin_on)
                begin
                    gives    = pin_gives;
                    want.deg = 8'(pin_deg);
                    want.rad = 15'(pin_rad);
                end
                if (gives)
                begin
                    expected_angles.push_back(want);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        row_kind_t   prev;
        logic [31:0] t;
        int          first;
        int          r;
        int unsigned per;

        for (int i = 0; i <= QUARTER; i++)
        begin
            quarter_sine[i] = taylor_q15(i);
        end
        period_ms = 16'd30;
        step      = 16'd993;
        amp       = 7'd45;
        offset    = 16'd0;
        stop      = 1'b0;
        rev       = 1'b0;
        last_ms   = '0;
        phase_acc = '0;
        errors    = 0;
        steady    = 1'b0;
        pin_on    = 1'b0;

        // Boundaries of the period, time wrap, quadrant extremes, saturation, stop
        plan.push_back(tp(32'd0, 0, 0, 0));
        plan.push_back(tp(32'd30, 0, 0, 0));
        plan.push_back(tp(32'd31, 1, 0, 0));
        plan.push_back(tm(32'hFFFF_FFFF));
        plan.push_back(tp(32'd20, 0, 0, 0));
        plan.push_back(tm(32'd40));
        plan.push_back(w(CFG_PHASE_STEP, 16'd62557));
        plan.push_back(tm(32'd100));
        plan.push_back(w(CFG_PHASE_STEP, 16'd0));
        plan.push_back(w(CFG_AMPLITUDE, 16'd90));
        plan.push_back(w(CFG_PHASE_OFFSET, 16'd16384));
        plan.push_back(tp(32'd200, 1, 90, 12868));
        plan.push_back(w(CFG_REVERSE, 16'd1));
        plan.push_back(tp(32'd300, 1, -90, -12868));
        plan.push_back(w(CFG_AMPLITUDE, 16'd127));
        plan.push_back(tp(32'd400, 1, -90, -12868));
        plan.push_back(w(CFG_PHASE_OFFSET, 16'd49152));
        plan.push_back(tp(32'd500, 1, 90, 12868));
        plan.push_back(w(CFG_PHASE_OFFSET, 16'd32768));
        plan.push_back(tp(32'd600, 1, 0, 0));
        plan.push_back(w(CFG_REVERSE, 16'd0));
        plan.push_back(w(CFG_PHASE_OFFSET, 16'd0));
        plan.push_back(w(CFG_PHASE_STEP, 16'd16384));
        plan.push_back(w(CFG_STOP_OUTPUT, 16'd1));
        plan.push_back(tp(32'd700, 0, 0, 0));
        plan.push_back(w(CFG_STOP_OUTPUT, 16'd0));
        plan.push_back(tp(32'd800, 1, 90, 12868));
        plan.push_back(w(CFG_SAMPLE_PERIOD, 16'd0));
        plan.push_back(tp(32'd800, 0, 0, 0));
        plan.push_back(tp(32'd801, 1, 0, 0));
        plan.push_back(w(CFG_SAMPLE_PERIOD, 16'd65535));
        plan.push_back(tp(32'd66336, 0, 0, 0));
        plan.push_back(tp(32'd66337, 1, -90, -12868));
        plan.push_back(w(CFG_AMPLITUDE, 16'd0));
        plan.push_back(tp(32'd200000, 1, 0, 0));

        // Hold reset, then release at a falling edge
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        prev = ROW_TIME;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (prev == ROW_TIME)
                begin
                    settle();
                end
                write_reg(plan[i].reg_idx, plan[i].value[15:0]);
            end
            else
            begin
                send_time(plan[i].value, plan[i].typed, plan[i].gives,
                          plan[i].deg, plan[i].rad);
            end
            prev = plan[i].kind;
        end

        // Random phases, each under its own configuration
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            steady = (ph == 4);
            unique case (ph)
                0: write_all(16'd30, 16'd993, 7'd45, 16'd0, 1'b0, 1'b0);
                1: write_all(16'd0, 16'hFFFF, 7'd90, 16'hFFFF, 1'b0, 1'b1);
                2: write_all(16'hFFFF, 16'($urandom), 7'd127, 16'($urandom), 1'b0, 1'b0);
                3: write_all(16'($urandom_range(0, 100)), 16'($urandom),
                             7'($urandom_range(0, 127)), 16'($urandom), 1'b1, 1'($urandom));
                default:
                    write_all($urandom_range(0, 99) < 70 ? 16'($urandom_range(0, 200))
                                                         : 16'($urandom),
                              16'($urandom), 7'($urandom_range(0, 127)), 16'($urandom),
                              $urandom_range(0, 9) == 0, 1'($urandom));
            endcase
            if (ph == 1)
            begin
                t = 32'hFFFF_FF00;
                send_time(t, 1'b0, 1'b0, 0, 0);
            end
            first = samples_taken;
            while (samples_taken - first < PER_PHASE)
            begin
                // Occasionally hold off until the pipeline is empty
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_empty();
                end
                per = period_ms;
                r   = $urandom_range(0, 99);
                if (r < 60)
                begin
                    t = last_ms + $urandom_range(per + 1, 2 * per + 2);
                end
                else if (r < 70)
                begin
                    t = last_ms + per + $urandom_range(0, 1);
                end
                else if (r < 85)
                begin
                    t = last_ms + $urandom_range(0, per);
                end
                else
                begin
                    t = $urandom;
                end
                send_time(t, 1'b0, 1'b0, 0, 0);
            end
        end
        steady = 1'b0;

        settle();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
